FILE: rtl/core/mcl_pkg.sv
// Shared types and constants for the minimum cover length search block.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package mcl_pkg;

  // Field widths fixed by the interface
  localparam int POS_W   = 30;
  localparam int LIMIT_W = 11;

  // Search bounds and working widths
  localparam int SRCH_W = 32;  // signed bounds, high may reach -1
  localparam int END_W  = 31;  // exclusive window end, position + length
  localparam int WCNT_W = 12;  // window count, at most limit + 1

  localparam logic signed [SRCH_W-1:0] LENGTH_TOP = 32'sd1000000005;

  // Request from the search sequencer to the probe unit
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] len;
  } probe_ctl_t;

  // Probe unit status back to the sequencer
  typedef struct packed {
    logic done;
    logic fits;
  } probe_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/mcl_point_mem.sv
// Point store: one write port, one read port with registered read data.
// Depends on mcl_pkg for the position width.
`default_nettype none

module mcl_point_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [ADDR_W-1:0]         waddr,
  input  wire  [mcl_pkg::POS_W-1:0] wdata,
  input  wire  [ADDR_W-1:0]         raddr,
  output logic [mcl_pkg::POS_W-1:0] rdata
);
  import mcl_pkg::*;

  logic [POS_W-1:0] mem [DEPTH];

  // Write loaded points
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle; the read data is registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mcl_probe.sv
// Probe unit: one greedy covering pass over the stored points for a given
// window length, one point per cycle through a shared add and compare.
// Depends on mcl_pkg for widths and the request and status structs.
`default_nettype none

module mcl_probe #(
  parameter int CNT_W  = 11,
  parameter int ADDR_W = 10
) (
  input  wire                         clk,
  input  wire                         rst,
  input  mcl_pkg::probe_ctl_t         ctl,
  input  wire  [CNT_W-1:0]            count,
  input  wire  [mcl_pkg::LIMIT_W-1:0] limit,
  output logic [ADDR_W-1:0]           rd_addr,
  input  wire  [mcl_pkg::POS_W-1:0]   rd_data,
  output mcl_pkg::probe_sts_t         sts
);
  import mcl_pkg::*;

  logic              active;
  logic [CNT_W-1:0]  iss;
  logic              ev_valid;
  logic              ev_first;
  logic              ev_last;
  logic [END_W-1:0]  end_excl;
  logic [WCNT_W-1:0] wcount;
  logic [POS_W-1:0]  len;

  logic              issue;
  logic              new_win;
  logic [WCNT_W-1:0] wc_new;
  logic [END_W-1:0]  end_new;
  logic              over;
  logic              finish;

  // Issue reads in order while points remain
  assign issue   = active && (iss < count);
  assign rd_addr = iss[ADDR_W-1:0];

  // Shared unit: open a window when the point lies past the current end
  always_comb begin
    new_win = ev_first || ({1'b0, rd_data} >= end_excl);
    end_new = {1'b0, rd_data} + {1'b0, len};
    if (ev_first) begin
      wc_new = WCNT_W'(1);
    end else if (new_win) begin
      wc_new = wcount + WCNT_W'(1);
    end else begin
      wc_new = wcount;
    end
    over   = wc_new > {{(WCNT_W-LIMIT_W){1'b0}}, limit};
    finish = ev_last || (new_win && over && !ev_first);
  end

  // Advance the pass one point per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      ev_valid <= 1'b0;
      sts      <= '0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.start) begin
        active   <= 1'b1;
        iss      <= '0;
        ev_valid <= 1'b0;
        len      <= ctl.len;
      end else if (active) begin
        if (issue) begin
          iss <= iss + CNT_W'(1);
        end
        ev_valid <= issue;
        ev_first <= (iss == '0);
        ev_last  <= (iss == count - CNT_W'(1));
        if (ev_valid) begin
          if (new_win) begin
            wcount   <= wc_new;
            end_excl <= end_new;
          end
          if (finish) begin
            sts.done <= 1'b1;
            sts.fits <= !over;
            active   <= 1'b0;
            ev_valid <= 1'b0;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A pass reports only while it runs
  a_done_from_active: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> $past(active))
    else $error("probe done without an active pass");

  // Early exit keeps the window count within limit plus one
  a_wcount_bound: assert property (@(posedge clk) disable iff (rst)
    (active && ev_valid && !ev_first) |->
      wcount <= {{(WCNT_W-LIMIT_W){1'b0}}, limit} + WCNT_W'(1))
    else $error("window count ran past limit");

  // Reads never go past the loaded points
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> iss <= count)
    else $error("probe read index past point count");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/min_cover_length_search.sv
`default_nettype none
// Minimum cover length search, top level.
// Depends on mcl_pkg, mcl_point_mem and mcl_probe.
//
// Usage:
// - Load points with start while busy is low; position and last_point are
//   taken at that edge, one point per cycle. Points past MAX_POINTS are
//   dropped; a dropped last point still closes the set.
// - The request with last_point set raises busy and runs a binary search
//   over window lengths 0 to 1000000005 (30 probes at most).
// - Each probe walks the stored points through the memory read port, one
//   point per cycle, and stops early once the window count exceeds the
//   limit.
// - The answer appears on min_length with done high for one cycle; busy
//   falls in the same cycle and the next request starts a new set.
// - The receiver cannot stall; the result must be taken when done is high.
// - segment_limit is written over cfg_valid/cfg_ready (ready always high)
//   by the user only while idle, not enforced by the block; resets to 1.
// - Synchronous reset empties the set and returns to idle; no clearing pass.

module min_cover_length_search #(
  parameter int MAX_POINTS = 1024
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [mcl_pkg::POS_W-1:0]   position,
  input  wire                         last_point,
  output logic                        done,
  output logic [mcl_pkg::POS_W-1:0]   min_length,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [mcl_pkg::LIMIT_W-1:0] segment_limit
);
  import mcl_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MID  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]               state;
  logic [CNT_W-1:0]         count;
  logic signed [SRCH_W-1:0] low;
  logic signed [SRCH_W-1:0] high;
  logic [POS_W-1:0]         mid;
  logic [POS_W-1:0]         best;
  logic [LIMIT_W-1:0]       limit;

  logic                     acc;
  logic                     mem_we;
  logic                     in_range;
  logic signed [SRCH_W-1:0] mid_sum;
  logic [ADDR_W-1:0]        rd_addr;
  logic [POS_W-1:0]         rd_data;
  probe_ctl_t               pctl;
  probe_sts_t               psts;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign mem_we    = acc && (count < CNT_W'(MAX_POINTS));
  assign in_range  = (low <= high);
  assign mid_sum   = (low + high) >>> 1;

  // Start a probe at the midpoint of the current bounds
  always_comb begin
    pctl.start = (state == S_MID) && in_range;
    pctl.len   = mid_sum[POS_W-1:0];
  end

  // Hold the window limit
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      limit <= segment_limit;
    end
  end

  // Load points, then sequence the binary search
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      low   <= '0;
      high  <= LENGTH_TOP;
      best  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (mem_we) begin
              count <= count + CNT_W'(1);
            end
            if (last_point) begin
              low   <= '0;
              high  <= LENGTH_TOP;
              best  <= '0;
              state <= S_MID;
            end
          end
        end
        S_MID: begin
          if (in_range) begin
            mid   <= pctl.len;
            state <= S_WAIT;
          end else begin
            min_length <= best;
            done       <= 1'b1;
            count      <= '0;
            state      <= S_IDLE;
          end
        end
        S_WAIT: begin
          if (psts.done) begin
            if (psts.fits) begin
              best <= mid;
              high <= {{(SRCH_W-POS_W){1'b0}}, mid} - SRCH_W'(1);
            end else begin
              low  <= {{(SRCH_W-POS_W){1'b0}}, mid} + SRCH_W'(1);
            end
            state <= S_MID;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mcl_point_mem #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (position),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mcl_probe #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_probe (
    .clk     (clk),
    .rst     (rst),
    .ctl     (pctl),
    .count   (count),
    .limit   (limit),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .sts     (psts)
  );

`ifndef NO_ASSERTIONS
  // A closing request always starts a search
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (acc && last_point) |=> busy)
    else $error("last point did not start a search");

  // The result leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  // Probe status arrives only while waiting for it
  a_sts_in_wait: assert property (@(posedge clk) disable iff (rst)
    psts.done |-> (state == S_WAIT))
    else $error("probe status outside wait");

  // Bounds stay within 0 to LENGTH_TOP while a probe is out
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (low >= 0 && high <= LENGTH_TOP))
    else $error("search bounds out of range");
`endif

endmodule

`default_nettype wire
